FILE: design/rmsq_pkg.sv
`timescale 1ns / 1ps
package rmsq_pkg;
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned IdxW = $clog2(MaxElements);
  localparam int unsigned CntW = 11;
  localparam int unsigned ValW = 32;
  localparam int unsigned SumW = 42;
  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef logic signed [SumW-1:0] sum_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    logic [ValW-1:0] wr_data;
    logic rd_en;
    idx_t rd_addr;
  } mem_req_t;
endpackage

FILE: design/rmsq_store.sv
`timescale 1ns / 1ps
module rmsq_store (
  input  logic clk,
  input  rmsq_pkg::mem_req_t req,
  output logic [rmsq_pkg::ValW-1:0] rd_data
);
  logic [rmsq_pkg::ValW-1:0] mem [rmsq_pkg::MaxElements];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

FILE: design/range_max_subarray_query.sv
`timescale 1ns / 1ps
// Maximum-sum contiguous subrange query over a stored array of signed 32-bit values.
// The request channel (valid/ready) carries either a write (action 0), which
// stores element_value at position and returns nothing, or a query (action 1)
// over the inclusive range [range_start, range_end]. Each query returns one
// result on the result channel: best_start, best_end, the 42-bit best_sum and
// range_error. A reversed range, or one whose end reaches element_count, is
// flagged with range_error and zeroed fields.
// A valid query scans the range one element per cycle through the element
// memory, which has one write port and one registered read port; no new
// request is taken until the scan is done and its result has moved into the
// output register. An invalid query has its result registered and valid in
// the cycle after acceptance. The result sits in an output register; the
// block takes the next request while it waits, and stalls only when a new
// result would need that register. Reset clears control state and sets
// element_count to 1024; the memory is not cleared, so elements must be
// written before a query covers them. element_count is to be written by the
// user through cfg_we/cfg_data while the block is idle; the block does not check.
module range_max_subarray_query (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rmsq_pkg::CntW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  input  logic [rmsq_pkg::IdxW-1:0] position,
  input  logic signed [rmsq_pkg::ValW-1:0] element_value,
  input  logic [rmsq_pkg::IdxW-1:0] range_start,
  input  logic [rmsq_pkg::IdxW-1:0] range_end,
  output logic out_valid,
  input  logic out_ready,
  output logic [rmsq_pkg::IdxW-1:0] best_start,
  output logic [rmsq_pkg::IdxW-1:0] best_end,
  output logic signed [rmsq_pkg::SumW-1:0] best_sum,
  output logic range_error
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state;
  logic [rmsq_pkg::CntW-1:0] element_count;
  rmsq_pkg::idx_t rd_idx, acc_idx, q_start, q_end, min_idx, bs, be;
  logic rd_last, acc_pend, acc_last, have;
  rmsq_pkg::sum_t prefix, min_prefix, best;
  rmsq_pkg::mem_req_t req;
  logic [rmsq_pkg::ValW-1:0] rd_data;
  logic accept, out_free, q_bad, load_res;
  logic [rmsq_pkg::CntW-1:0] limit;

  // Effective count never exceeds the memory depth.
  assign limit = (element_count > rmsq_pkg::CntW'(rmsq_pkg::MaxElements))
                 ? rmsq_pkg::CntW'(rmsq_pkg::MaxElements) : element_count;
  assign out_free = !out_valid || out_ready;
  // Only an invalid query needs the output register at once; writes and
  // valid queries are taken while a result waits.
  assign in_ready = (state == StIdle) &&
                    (out_free || (action == rmsq_pkg::ActWrite) || !q_bad);
  assign accept = in_valid && in_ready;
  assign q_bad = (range_start > range_end) ||
                 ({1'b0, range_end} >= limit);
  assign load_res = ((state == StIdle) && accept && (action == rmsq_pkg::ActQuery) && q_bad)
                    || ((state == StDone) && out_free);

  always_comb begin
    req.wr_en = accept && (action == rmsq_pkg::ActWrite);
    req.wr_addr = position;
    req.wr_data = element_value;
    req.rd_en = ((state == StIdle) && accept && (action == rmsq_pkg::ActQuery))
                || ((state == StScan) && !rd_last);
    req.rd_addr = (state == StIdle) ? range_start : rd_idx;
  end

  rmsq_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

  // Kadane-style scan terms for the element arriving from memory.
  rmsq_pkg::sum_t new_prefix, cand;
  logic take_min;
  rmsq_pkg::sum_t mp;
  rmsq_pkg::idx_t mi;
  always_comb begin
    take_min = (acc_idx == q_start) || (prefix < min_prefix);
    mp = take_min ? prefix : min_prefix;
    mi = take_min ? acc_idx : min_idx;
    new_prefix = prefix + rmsq_pkg::SumW'($signed(rd_data));
    cand = new_prefix - mp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      element_count <= rmsq_pkg::CntW'(1024);
      out_valid <= 1'b0;
      acc_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        element_count <= cfg_data;
      end
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (accept && action == rmsq_pkg::ActQuery) begin
            if (q_bad) begin
              best_start <= '0;
              best_end <= '0;
              best_sum <= '0;
              range_error <= 1'b1;
            end else begin
              state <= StScan;
              q_start <= range_start;
              q_end <= range_end;
              rd_idx <= range_start + 1'b1;
              rd_last <= (range_start == range_end);
              acc_idx <= range_start;
              acc_last <= (range_start == range_end);
              acc_pend <= 1'b1;
              prefix <= '0;
              min_prefix <= '0;
              min_idx <= range_start;
              have <= 1'b0;
            end
          end
        end
        StScan: begin
          if (!rd_last) begin
            rd_idx <= rd_idx + 1'b1;
            rd_last <= (rd_idx == q_end);
          end
          if (acc_pend) begin
            prefix <= new_prefix;
            min_prefix <= mp;
            min_idx <= mi;
            if (!have || cand > best || (cand == best && mi < bs)) begin
              best <= cand;
              bs <= mi;
              be <= acc_idx;
              have <= 1'b1;
            end
            acc_idx <= acc_idx + 1'b1;
            if (acc_last) begin
              acc_pend <= 1'b0;
              state <= StDone;
            end else begin
              acc_last <= (acc_idx + 1'b1 == q_end);
            end
          end
        end
        StDone: begin
          if (out_free) begin
            best_start <= bs;
            best_end <= be;
            best_sum <= best;
            range_error <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

FILE: design/rmsq_checker.sv
`timescale 1ns / 1ps
module rmsq_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic action,
  input logic out_valid,
  input logic out_ready,
  input logic [rmsq_pkg::IdxW-1:0] best_start,
  input logic [rmsq_pkg::IdxW-1:0] best_end,
  input logic range_error
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_start) && $stable(best_end))
    else $error("result changed while stalled");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> best_start <= best_end)
    else $error("best_start after best_end");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> best_start == '0 && best_end == '0)
    else $error("error result not zeroed");
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == rmsq_pkg::ActWrite && !out_valid |=> !out_valid)
    else $error("write produced a result");
endmodule

bind range_max_subarray_query rmsq_checker u_rmsq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
  .out_valid(out_valid), .out_ready(out_ready), .best_start(best_start),
  .best_end(best_end), .range_error(range_error)
);

FILE: sim/tb_range_max_subarray_query.sv
`timescale 1ns / 1ps
module tb_range_max_subarray_query;

  typedef struct packed {
    logic [rmsq_pkg::IdxW-1:0] first;
    logic [rmsq_pkg::IdxW-1:0] last;
    logic [rmsq_pkg::SumW-1:0] total;
    logic err;
  } span_result_t;

  // The scoreboard keeps a shadow copy of the element array and the element
  // count. It computes the best subrange for each accepted query and holds
  // the answers in arrival order.
  class span_board;
    logic signed [rmsq_pkg::ValW-1:0] shadow[rmsq_pkg::MaxElements];
    int unsigned count_in_use;
    span_result_t pending[$];
    int errors;

    function void clear();
      count_in_use = 1024;
      pending.delete();
      errors = 0;
    endfunction

    // Note one accepted request. Writes update the shadow array. Queries
    // scan the range with a running prefix, and the earliest minimal prefix
    // gives the start.
    function void note_request(logic act, logic [rmsq_pkg::IdxW-1:0] pos,
                               logic signed [rmsq_pkg::ValW-1:0] v,
                               logic [rmsq_pkg::IdxW-1:0] rs, logic [rmsq_pkg::IdxW-1:0] re);
      span_result_t r;
      longint prefix, min_prefix, best, cand;
      int min_idx, bs, be;
      bit have;
      int unsigned lim;
      if (act == rmsq_pkg::ActWrite) begin
        shadow[pos] = v;
        return;
      end
      lim = (count_in_use > rmsq_pkg::MaxElements) ? rmsq_pkg::MaxElements : count_in_use;
      r = '0;
      if (rs > re || re >= lim) begin
        r.err = 1'b1;
        pending.push_back(r);
        return;
      end
      prefix = 0; min_prefix = 0; min_idx = rs; best = 0; bs = rs; be = rs; have = 0;
      for (int j = rs; j <= re; j++) begin
        if (j == rs || prefix < min_prefix) begin
          min_prefix = prefix;
          min_idx = j;
        end
        prefix += longint'(shadow[j]);
        cand = prefix - min_prefix;
        if (!have || cand > best || (cand == best && min_idx < bs)) begin
          best = cand; bs = min_idx; be = j; have = 1;
        end
      end
      r.first = bs[rmsq_pkg::IdxW-1:0];
      r.last = be[rmsq_pkg::IdxW-1:0];
      r.total = best[rmsq_pkg::SumW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(span_result_t got);
      span_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no query waiting");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.first !== exp_r.first) begin
        $error("best_start expected %0d actual %0d", exp_r.first, got.first); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("best_end expected %0d actual %0d", exp_r.last, got.last); errors++;
      end
      if (got.total !== exp_r.total) begin
        $error("best_sum expected %0h actual %0h", exp_r.total, got.total); errors++;
      end
      if (got.err !== exp_r.err) begin
        $error("range_error expected %0d actual %0d", exp_r.err, got.err); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [rmsq_pkg::CntW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic action = 0;
  logic [rmsq_pkg::IdxW-1:0] position = '0;
  logic signed [rmsq_pkg::ValW-1:0] element_value = '0;
  logic [rmsq_pkg::IdxW-1:0] range_start = '0;
  logic [rmsq_pkg::IdxW-1:0] range_end = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [rmsq_pkg::IdxW-1:0] best_start;
  logic [rmsq_pkg::IdxW-1:0] best_end;
  logic signed [rmsq_pkg::SumW-1:0] best_sum;
  logic range_error;

  range_max_subarray_query dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .position(position),
    .element_value(element_value), .range_start(range_start), .range_end(range_end),
    .out_valid(out_valid), .out_ready(out_ready), .best_start(best_start),
    .best_end(best_end), .best_sum(best_sum), .range_error(range_error)
  );

  always #6 clk = ~clk;

  span_board board = new();

  // Idle rates in percent. The sender and receiver settings change per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;
  int idle_cycles = 0;

  // Results are sampled at the rising edge. The receiver's ready changes at
  // the falling edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{best_start, best_end, best_sum, range_error});
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (recv_hold) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The watchdog counts cycles in which nothing moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || recv_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one request and wait until it is accepted. A random gap comes first,
  // and the payload is recorded at the accepting edge. Valid is driven with
  // blocking assignments so that a back-to-back request can raise it again
  // at the same falling edge.
  task automatic send_request(logic act, logic [rmsq_pkg::IdxW-1:0] pos,
                              logic signed [rmsq_pkg::ValW-1:0] v,
                              logic [rmsq_pkg::IdxW-1:0] rs, logic [rmsq_pkg::IdxW-1:0] re);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1;
    action <= act;
    position <= pos;
    element_value <= v;
    range_start <= rs;
    range_end <= re;
    do @(posedge clk); while (!in_ready);
    board.note_request(act, pos, v, rs, re);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Wait until every expected result has arrived, plus some slack for a
  // trailing write. set_count calls this before it writes the element count.
  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_count(int unsigned n);
    wait_drained();
    cfg_we <= 1;
    cfg_data <= n[rmsq_pkg::CntW-1:0];
    @(negedge clk);
    cfg_we <= 0;
    board.count_in_use = n[rmsq_pkg::CntW-1:0];
  endtask

  function automatic logic signed [rmsq_pkg::ValW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Random query over a written region. Most queries are short so that the
  // scans stay fast, a few cover the whole span, and some have random ends.
  task automatic random_query(int unsigned span);
    int unsigned a, b, len;
    if ($urandom_range(99) < 8) begin
      a = $urandom_range(1023);
      b = $urandom_range(1023);
    end else if ($urandom_range(99) < 3) begin
      a = 0;
      b = span - 1;
    end else begin
      len = $urandom_range(24);
      a = $urandom_range(span - 1);
      b = (a + len > span - 1) ? span - 1 : a + len;
    end
    send_request(rmsq_pkg::ActQuery, rmsq_pkg::IdxW'($urandom), rmsq_pkg::ValW'($urandom),
                 a[rmsq_pkg::IdxW-1:0], b[rmsq_pkg::IdxW-1:0]);
  endtask

  task automatic random_phase(int unsigned n, int unsigned span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 45)
        send_request(rmsq_pkg::ActWrite, rmsq_pkg::IdxW'($urandom_range(span - 1)),
                     pick_value(), rmsq_pkg::IdxW'($urandom), rmsq_pkg::IdxW'($urandom));
      else
        random_query(span);
    end
  endtask

  initial begin
    board.clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Fill the whole store once so that no query reads an element that was
    // never written.
    send_idle_pct = 8;
    recv_idle_pct = 86;
    for (int i = 0; i < rmsq_pkg::MaxElements; i++)
      send_request(rmsq_pkg::ActWrite, i[rmsq_pkg::IdxW-1:0],
                   (i % 3 == 0) ? rmsq_pkg::ValW'(-i) : rmsq_pkg::ValW'($urandom),
                   rmsq_pkg::IdxW'($urandom), rmsq_pkg::IdxW'($urandom));

    // Directed queries cover the extremes, a full-range scan, single elements,
    // reversed ranges, and an end at the count limit.
    send_request(rmsq_pkg::ActWrite, 0, 32'sh7fffffff, 0, 0);
    send_request(rmsq_pkg::ActWrite, 1, 32'sh7fffffff, 0, 0);
    send_request(rmsq_pkg::ActWrite, 1023, 32'sh80000000, 10'h3ff, 10'h3ff);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 0);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 1);
    send_request(rmsq_pkg::ActQuery, 0, 0, 1023, 1023);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 1023);
    send_request(rmsq_pkg::ActQuery, 0, 0, 5, 4);
    send_request(rmsq_pkg::ActQuery, 0, 0, 1023, 0);
    for (int i = 2; i < 10; i++) send_request(rmsq_pkg::ActWrite, i[rmsq_pkg::IdxW-1:0], 0, 0, 0);
    send_request(rmsq_pkg::ActQuery, 0, 0, 2, 9);
    for (int i = 10; i < 14; i++)
      send_request(rmsq_pkg::ActWrite, i[rmsq_pkg::IdxW-1:0], 32'sh80000000, 0, 0);
    send_request(rmsq_pkg::ActQuery, 0, 0, 10, 13);

    // Sweep the element count through its extremes, with queries at the
    // edge of each setting.
    set_count(1);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 0);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 1);
    set_count(0);
    send_request(rmsq_pkg::ActQuery, 0, 0, 0, 0);
    set_count(2047);
    send_request(rmsq_pkg::ActQuery, 0, 0, 1020, 1023);
    set_count(37);
    send_request(rmsq_pkg::ActQuery, 0, 0, 30, 36);
    send_request(rmsq_pkg::ActQuery, 0, 0, 30, 37);
    random_phase(100, 64);
    set_count(1024);

    // Hold the receiver off for a long time while requests keep coming, so
    // that the result register fills and the input stalls.
    fork
      begin
        recv_hold = 1;
        repeat (600) @(negedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 6; i++)
        send_request(rmsq_pkg::ActQuery, 0, 0, i[rmsq_pkg::IdxW-1:0],
                     rmsq_pkg::IdxW'(i + 2));
    join

    random_phase(120, 1024);
    send_idle_pct = 86;
    recv_idle_pct = 8;
    set_count(200);
    random_phase(130, 256);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_count(1024);
    random_phase(140, 1024);

    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
design/rmsq_pkg.sv
design/rmsq_store.sv
design/range_max_subarray_query.sv
design/rmsq_checker.sv
sim/tb_range_max_subarray_query.sv
